// ===== hw/rtl/lse_pkg.sv =====
// Shared types and constants for the LIFO stack engine.
package lse_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned DefDepth = 8;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_DUMP = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PUSH = 2'd1,
    CELL_POP  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_DUMP = 1'b1
  } fsm_e;

  typedef struct packed {
    cell_op_e op;
    logic     wrap;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/lse_if.sv =====
// Valid/ready channel interfaces for stack commands and results.
interface lse_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [lse_pkg::CmdW-1:0]            command;
  logic signed [lse_pkg::DataW-1:0]    push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface lse_res_if;
  logic                                valid;
  logic                                ready;
  logic [lse_pkg::StatusW-1:0]         status;
  logic signed [lse_pkg::DataW-1:0]    data_out;
  logic                                full_flag;
  logic                                empty_flag;
  logic                                last;

  modport source (output valid, output status, output data_out, output full_flag,
                  output empty_flag, output last, input ready);
  modport sink   (input valid, input status, input data_out, input full_flag,
                  input empty_flag, input last, output ready);
endinterface

// ===== hw/rtl/lifo_stack_engine.sv =====
// Push, pop and peek give their word in the cycle after acceptance.
// Throughput: one push, pop or peek per cycle while the output is free; a
// dump of N entries emits N words in turn and blocks input until done.
// The rate is set by the single output register and the cell chain shift.
// Reset clears the fill count, control state and output valid; cell
// contents are left as they are.
module lifo_stack_engine #(
  parameter int unsigned DEPTH = lse_pkg::DefDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lse_cmd_if.sink       in_i,
  lse_res_if.source     out_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic signed [lse_pkg::DataW-1:0] cell_data [DEPTH];
  lse_pkg::cell_ctl_t               cell_ctl  [DEPTH];
  lse_pkg::cell_op_e                cell_op;

  lse_pkg::fsm_e   state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rem_q, rem_d;

  logic                              valid_q, valid_d;
  logic [lse_pkg::StatusW-1:0]       status_q, status_d;
  logic signed [lse_pkg::DataW-1:0]  data_q, data_d;
  logic                              full_q, full_d;
  logic                              empty_q, empty_d;
  logic                              last_q, last_d;

  logic out_free, accept, load;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [lse_pkg::DataW-1:0] above, below;
    if (i == 0) begin : g_top
      assign above = in_i.push_value;
    end else begin : g_mid
      assign above = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_bot
      assign below = cell_data[i];
    end else begin : g_up
      assign below = cell_data[i+1];
    end
    assign cell_ctl[i].op   = cell_op;
    assign cell_ctl[i].wrap = (count_q == CntW'(i + 1));

    lse_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl[i]),
      .above_i (above),
      .below_i (below),
      .top_i   (cell_data[0]),
      .data_o  (cell_data[i])
    );
  end

  assign out_free  = !valid_q || out_o.ready;
  assign in_i.ready = (state_q == lse_pkg::FSM_IDLE) && out_free;
  assign accept    = in_i.valid && in_i.ready;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rem_d    = rem_q;
    cell_op  = lse_pkg::CELL_HOLD;
    load     = 1'b0;
    valid_d  = valid_q && !out_o.ready;
    status_d = status_q;
    data_d   = data_q;
    full_d   = full_q;
    empty_d  = empty_q;
    last_d   = last_q;

    if (accept) begin
      load     = 1'b1;
      status_d = lse_pkg::ST_OK;
      data_d   = '0;
      last_d   = 1'b1;
      case (lse_pkg::cmd_e'(in_i.command))
        lse_pkg::CMD_PUSH: begin
          if (count_q == CntW'(DEPTH)) begin
            status_d = lse_pkg::ST_FULL;
          end else begin
            cell_op = lse_pkg::CELL_PUSH;
            count_d = count_q + 1'b1;
          end
        end
        lse_pkg::CMD_POP: begin
          if (count_q == '0) begin
            status_d = lse_pkg::ST_EMPTY;
          end else begin
            cell_op = lse_pkg::CELL_POP;
            count_d = count_q - 1'b1;
            data_d  = cell_data[0];
          end
        end
        lse_pkg::CMD_PEEK: begin
          if (count_q == '0) begin
            status_d = lse_pkg::ST_EMPTY;
          end else begin
            data_d = cell_data[0];
          end
        end
        lse_pkg::CMD_DUMP: begin
          if (count_q == '0) begin
            status_d = lse_pkg::ST_EMPTY;
          end else begin
            // emit the top now and rotate; N rotations restore the order
            cell_op = lse_pkg::CELL_ROT;
            data_d  = cell_data[0];
            rem_d   = count_q - 1'b1;
            last_d  = (count_q == CntW'(1));
            if (count_q != CntW'(1)) begin
              state_d = lse_pkg::FSM_DUMP;
            end
          end
        end
        default: begin
          status_d = lse_pkg::ST_OK;
        end
      endcase
    end else if (state_q == lse_pkg::FSM_DUMP && out_free) begin
      load     = 1'b1;
      cell_op  = lse_pkg::CELL_ROT;
      status_d = lse_pkg::ST_OK;
      data_d   = cell_data[0];
      rem_d    = rem_q - 1'b1;
      last_d   = (rem_q == CntW'(1));
      if (rem_q == CntW'(1)) begin
        state_d = lse_pkg::FSM_IDLE;
      end
    end

    if (load) begin
      valid_d = 1'b1;
      full_d  = (count_d == CntW'(DEPTH));
      empty_d = (count_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lse_pkg::FSM_IDLE;
      count_q <= '0;
      rem_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rem_q   <= rem_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    data_q   <= data_d;
    full_q   <= full_d;
    empty_q  <= empty_d;
    last_q   <= last_d;
  end

  assign out_o.valid      = valid_q;
  assign out_o.status     = status_q;
  assign out_o.data_out   = data_q;
  assign out_o.full_flag  = full_q;
  assign out_o.empty_flag = empty_q;
  assign out_o.last       = last_q;

endmodule

// ===== hw/rtl/lse_cell.sv =====
// One stack cell: holds a word, loads from its upper or lower neighbor or the top.
module lse_cell (
  input  logic                              clk_i,
  input  lse_pkg::cell_ctl_t                ctl_i,
  input  logic signed [lse_pkg::DataW-1:0]  above_i,
  input  logic signed [lse_pkg::DataW-1:0]  below_i,
  input  logic signed [lse_pkg::DataW-1:0]  top_i,
  output logic signed [lse_pkg::DataW-1:0]  data_o
);

  logic signed [lse_pkg::DataW-1:0] data_q, data_d;

  always_comb begin
    case (ctl_i.op)
      lse_pkg::CELL_HOLD: data_d = data_q;
      lse_pkg::CELL_PUSH: data_d = above_i;
      lse_pkg::CELL_POP:  data_d = below_i;
      // bottom occupied cell takes the old top word during a dump rotation
      lse_pkg::CELL_ROT:  data_d = ctl_i.wrap ? top_i : below_i;
      default:            data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the LIFO stack engine: directed and random commands.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = lse_pkg::DefDepth;
  localparam int NUM_RANDOM = 400;
  localparam int HOLD_AT = 60;
  localparam int HOLD_CYCLES = 80;
  localparam int CALM_FROM = 150;
  localparam int CALM_TO = 250;
  localparam int DRAIN_AT = 250;

  typedef struct {
    lse_pkg::cmd_e      cmd;
    logic signed [31:0] value;
    bit                 drain;  // hold this word back until all results are in
  } stack_cmd_t;

  typedef struct {
    lse_pkg::status_e   status;
    logic signed [31:0] data;
    logic               full;
    logic               empty;
    logic               last;
  } res_word_t;

  logic clk;
  logic rst_n;

  lse_cmd_if cmd_ch();
  lse_res_if res_ch();

  lifo_stack_engine #(.DEPTH(DEPTH)) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_ch),
    .out_o  (res_ch)
  );

  stack_cmd_t         pend_q[$];
  res_word_t          expected_words[$];
  logic signed [31:0] stack_mem[DEPTH];
  int                 stack_fill = 0;
  int                 acc_cnt;
  int                 n_mismatch = 0;
  int                 hold_left = 0;
  bit                 hold_done = 1'b0;
  stack_cmd_t         nxt;
  res_word_t          got_exp;

  wire calm = (acc_cnt >= CALM_FROM) && (acc_cnt < CALM_TO);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void note_word(lse_pkg::status_e st, logic signed [31:0] data,
                                    bit is_last);
    res_word_t w;
    w.status = st;
    w.data   = data;
    w.full   = (stack_fill == DEPTH);
    w.empty  = (stack_fill == 0);
    w.last   = is_last;
    expected_words.push_back(w);
  endfunction

  function automatic void predict_cmd(lse_pkg::cmd_e cmd, logic signed [31:0] val);
    case (cmd)
      lse_pkg::CMD_PUSH: begin
        if (stack_fill == DEPTH) begin
          note_word(lse_pkg::ST_FULL, '0, 1'b1);
        end else begin
          stack_mem[stack_fill] = val;
          stack_fill++;
          note_word(lse_pkg::ST_OK, '0, 1'b1);
        end
      end
      lse_pkg::CMD_POP: begin
        if (stack_fill == 0) begin
          note_word(lse_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          stack_fill--;
          note_word(lse_pkg::ST_OK, stack_mem[stack_fill], 1'b1);
        end
      end
      lse_pkg::CMD_PEEK: begin
        if (stack_fill == 0) note_word(lse_pkg::ST_EMPTY, '0, 1'b1);
        else note_word(lse_pkg::ST_OK, stack_mem[stack_fill-1], 1'b1);
      end
      default: begin
        if (stack_fill == 0) begin
          note_word(lse_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          for (int k = stack_fill - 1; k >= 0; k--) begin
            note_word(lse_pkg::ST_OK, stack_mem[k], k == 0);
          end
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      n_mismatch++;
    end
  endfunction

  function automatic void queue_cmd(lse_pkg::cmd_e cmd, logic signed [31:0] val, bit drain);
    stack_cmd_t c;
    c.cmd   = cmd;
    c.value = val;
    c.drain = drain;
    pend_q.push_back(c);
  endfunction

  // command driver; predicts results at acceptance
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      cmd_ch.valid      <= 1'b0;
      cmd_ch.command    <= lse_pkg::CMD_PUSH;
      cmd_ch.push_value <= '0;
      acc_cnt           <= 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        predict_cmd(lse_pkg::cmd_e'(cmd_ch.command), cmd_ch.push_value);
        acc_cnt <= acc_cnt + 1;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (pend_q.size() == 0 || (!calm && $urandom_range(0, 99) < 11) ||
            (pend_q[0].drain && expected_words.size() != 0)) begin
          cmd_ch.valid <= 1'b0;
        end else begin
          nxt = pend_q.pop_front();
          cmd_ch.valid      <= 1'b1;
          cmd_ch.command    <= nxt.cmd;
          cmd_ch.push_value <= nxt.value;
        end
      end
    end
  end

  // result monitor and ready generation
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: status %h data %h", res_ch.status, res_ch.data_out);
          n_mismatch++;
        end else begin
          got_exp = expected_words.pop_front();
          check_field("status", 32'(got_exp.status), 32'(res_ch.status));
          check_field("data_out", got_exp.data, res_ch.data_out);
          check_field("full_flag", 32'(got_exp.full), 32'(res_ch.full_flag));
          check_field("empty_flag", 32'(got_exp.empty), 32'(res_ch.empty_flag));
          check_field("last", 32'(got_exp.last), 32'(res_ch.last));
        end
      end
      // one long hold-off so the stack backs up and input stalls
      if (!hold_done && acc_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= calm || ($urandom_range(0, 99) >= 11);
      end
    end
  end

  initial begin
    int                 bias;
    int                 roll;
    int                 push_pct;
    logic signed [31:0] val;
    lse_pkg::cmd_e      c;

    rst_n = 1'b0;

    // empty stack cases
    queue_cmd(lse_pkg::CMD_POP, 32'h0000_0000, 1'b0);
    queue_cmd(lse_pkg::CMD_PEEK, 32'hFFFF_FFFF, 1'b0);
    queue_cmd(lse_pkg::CMD_DUMP, 32'h1234_5678, 1'b0);
    // fill to the top with extreme values
    queue_cmd(lse_pkg::CMD_PUSH, 32'h8000_0000, 1'b0);
    queue_cmd(lse_pkg::CMD_PUSH, 32'hFFFF_FFFF, 1'b0);
    queue_cmd(lse_pkg::CMD_PUSH, 32'h7FFF_FFFF, 1'b0);
    queue_cmd(lse_pkg::CMD_PUSH, 32'h0000_0000, 1'b0);
    queue_cmd(lse_pkg::CMD_PUSH, 32'hAAAA_AAAA, 1'b0);
    queue_cmd(lse_pkg::CMD_PUSH, 32'h5555_5555, 1'b0);
    queue_cmd(lse_pkg::CMD_PUSH, 32'h0000_0001, 1'b0);
    queue_cmd(lse_pkg::CMD_PUSH, $urandom(), 1'b0);
    queue_cmd(lse_pkg::CMD_PUSH, 32'h0BAD_F00D, 1'b0);  // refused, stack full
    queue_cmd(lse_pkg::CMD_PEEK, 32'h0, 1'b0);
    queue_cmd(lse_pkg::CMD_DUMP, 32'h0, 1'b0);
    for (int i = 0; i < DEPTH; i++) queue_cmd(lse_pkg::CMD_POP, $urandom(), 1'b0);
    queue_cmd(lse_pkg::CMD_POP, 32'h0, 1'b0);
    // -1 must read back as data, not empty
    queue_cmd(lse_pkg::CMD_PUSH, 32'hFFFF_FFFF, 1'b0);
    queue_cmd(lse_pkg::CMD_DUMP, 32'h0, 1'b0);

    // random phases favour filling, draining or neither, chosen at random
    bias = 1;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 24 == 0) bias = $urandom_range(0, 2);
      push_pct = (bias == 2) ? 70 : (bias == 0) ? 25 : 45;
      roll = $urandom_range(0, 99);
      if (roll < push_pct) begin
        c = lse_pkg::CMD_PUSH;
      end else begin
        roll = $urandom_range(0, 99);
        c = (roll < 45) ? lse_pkg::CMD_POP : (roll < 75) ? lse_pkg::CMD_PEEK :
            lse_pkg::CMD_DUMP;
      end
      case ($urandom_range(0, 7))
        0: val = 32'h8000_0000;
        1: val = 32'h7FFF_FFFF;
        2: val = 32'hFFFF_FFFF;
        3: val = 32'h0000_0000;
        default: val = $urandom();
      endcase
      queue_cmd(c, val, n == 0 || n == DRAIN_AT);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (!(pend_q.size() == 0 && !cmd_ch.valid && expected_words.size() == 0)) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lse_pkg.sv
hw/rtl/lse_if.sv
hw/rtl/lse_cell.sv
hw/rtl/lifo_stack_engine.sv
tb/sv/tb_top.sv
